@@ src/mbd_pkg.sv @@
// Shared constants for the motion blink event detector.
package mbd_pkg;

    localparam int FACE_WIDTH_BITS      = 10;
    localparam int BLOCK_COUNT_BITS     = 12;
    localparam int COUNT_BITS_DEF       = 12;
    localparam int MAX_TRACK_FRAMES_DEF = 7;
    localparam int FRAMES_BITS          = 4;

    // m = floor(w*w*5/10000) = floor(floor(w*w/16)/125)
    localparam int SQ_BITS      = 2 * FACE_WIDTH_BITS;
    localparam int PRE_SHIFT    = 4;
    localparam int QUOT_IN_BITS = SQ_BITS - PRE_SHIFT;
    localparam int RECIP_SHIFT  = 23;
    localparam int RECIP_BITS   = 17;
    localparam logic [RECIP_BITS-1:0] RECIP_125 = 17'd67109;  // ceil(2^23/125)
    localparam int PROD_BITS    = QUOT_IN_BITS + RECIP_BITS;
    localparam int M_BITS       = 10;                         // m <= 523

endpackage

@@ src/mbd_if.sv @@
// Request and response channel interfaces for the motion blink event detector.
interface mbd_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [mbd_pkg::FACE_WIDTH_BITS-1:0]      face_width;
    logic [mbd_pkg::BLOCK_COUNT_BITS-1:0]     block_count;
    logic                                     global_motion;

    modport source (output valid, face_width, block_count, global_motion, input ready);
    modport sink   (input valid, face_width, block_count, global_motion, output ready);
endinterface

interface mbd_rsp_if;
    logic valid;
    logic ready;
    logic blink;
    logic capture_reference;
    logic tracking;

    modport source (output valid, blink, capture_reference, tracking, input ready);
    modport sink   (input valid, blink, capture_reference, tracking, output ready);
endinterface

@@ src/motion_blink_event_detector_top.sv @@
// Motion blink event detector: per-frame blink tracker with a four-stage pipeline.
//
// One request per video frame carries the face width, the count of moving
// blocks in the eye area and a whole-face motion flag; one response per
// request reports blink, capture_reference and tracking. The block takes a
// new request every cycle while the sink takes each response as it is
// presented. A request passes through the input register, squaring stage,
// threshold stage and result register before its response is presented. The
// threshold m = floor(w*w/2000) is computed as a
// square followed by a reciprocal multiply, each in its own stage; the
// tracking state machine updates in the last stage only, so consecutive
// frames see each other's state with no gap. Every stage has its own valid
// bit and moves when the stage after it is free, so bubbles close up and a
// response held by the sink still lets upstream stages fill.
module motion_blink_event_detector_top #(
    parameter int COUNT_BITS       = mbd_pkg::COUNT_BITS_DEF,
    parameter int MAX_TRACK_FRAMES = mbd_pkg::MAX_TRACK_FRAMES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbd_req_if.sink      i_req,
    mbd_rsp_if.source    o_rsp
);

    localparam int FW = mbd_pkg::FACE_WIDTH_BITS;
    localparam int MB = mbd_pkg::M_BITS;
    localparam int FB = mbd_pkg::FRAMES_BITS;
    // wide enough for 10*c and 7*m
    localparam int WB = COUNT_BITS + 5;

    typedef enum logic {ST_IDLE, ST_TRACK} t_state;

    // ---------------- pipeline stages ----------------
    logic                  r_v1, r_v2, r_v3, r_v4;
    logic [FW-1:0]         r_w1;
    logic [COUNT_BITS-1:0] r_c1, r_c2, r_c3;
    logic                  r_mot1, r_mot2, r_mot3;
    logic [mbd_pkg::SQ_BITS-1:0] r_sq2;
    logic [MB-1:0]         r_m3;

    logic rdy1, rdy2, rdy3, rdy4;
    logic [mbd_pkg::PROD_BITS-1:0] prod;

    assign rdy4 = !r_v4 || o_rsp.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign i_req.ready = rdy1;

    // floor(sq/16) * ceil(2^23/125) >> 23 is exact for 16-bit operands
    assign prod = mbd_pkg::PROD_BITS'(r_sq2[mbd_pkg::SQ_BITS-1:mbd_pkg::PRE_SHIFT])
                * mbd_pkg::PROD_BITS'(mbd_pkg::RECIP_125);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_req.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
        // payload
        if (rdy1 && i_req.valid) begin
            r_w1   <= i_req.face_width;
            r_c1   <= COUNT_BITS'(i_req.block_count);  // mask/extend to count width
            r_mot1 <= i_req.global_motion;
        end
        if (rdy2 && r_v1) begin
            r_sq2  <= mbd_pkg::SQ_BITS'(r_w1) * mbd_pkg::SQ_BITS'(r_w1);
            r_c2   <= r_c1;
            r_mot2 <= r_mot1;
        end
        if (rdy3 && r_v2) begin
            r_m3   <= prod[mbd_pkg::RECIP_SHIFT +: MB];
            r_c3   <= r_c2;
            r_mot3 <= r_mot2;
        end
    end

    // ---------------- tracking state machine ----------------
    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_prev, n_prev;
    logic [COUNT_BITS-1:0] r_peak, n_peak;
    logic [FB-1:0]         r_frames, n_frames;
    logic                  r_blink, n_blink;
    logic                  r_cap, n_cap;

    logic [WB-1:0] c_x, m_x, prev_x, peak_x;
    logic [WB-1:0] c10, c2, m7, m3, m2, m4;
    logic [FB:0]   n_cnt;
    logic          enter, late, early, reject;
    logic          fire;

    assign c_x    = WB'(r_c3);
    assign m_x    = WB'(r_m3);
    assign prev_x = WB'(r_prev);
    assign c10    = (c_x << 3) + (c_x << 1);
    assign c2     = c_x << 1;
    assign m7     = (m_x << 3) - m_x;
    assign m3     = (m_x << 1) + m_x;
    assign m2     = m_x << 1;
    assign m4     = m_x << 2;
    assign n_cnt  = (FB+1)'(r_frames) + (FB+1)'(1);
    assign fire   = r_v3 && rdy4;

    always_comb begin
        n_state  = r_state;
        n_prev   = r_prev;
        n_peak   = r_peak;
        n_frames = r_frames;
        n_blink  = 1'b0;
        n_cap    = 1'b0;
        peak_x   = WB'(r_peak);
        enter    = (c10 > m7) && (c_x < m3) && r_mot3;
        late     = 1'b0;
        early    = 1'b0;
        reject   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_prev = r_c3;
                if (enter) begin
                    n_state  = ST_TRACK;
                    n_peak   = r_c3;
                    n_frames = '0;
                    n_cap    = 1'b1;
                end
            end
            ST_TRACK: begin
                n_frames = n_cnt[FB-1:0];
                if (r_c3 > r_peak) begin
                    n_peak = r_c3;
                end
                late   = (c_x < peak_x) && (c_x <= m2) && !r_mot3 && (c_x < prev_x)
                       && (n_cnt > (FB+1)'(1));
                early  = (n_cnt == (FB+1)'(1)) && (c2 <= m_x) && (prev_x > m_x)
                       && !r_mot3 && (c_x < prev_x);
                reject = (n_cnt == (FB+1)'(1)) && !r_mot3
                       && ((c2 < m_x) || (c_x > prev_x) || (c_x > m_x));
                if (late || early) begin
                    n_blink = 1'b1;
                    n_state = ST_IDLE;
                    n_prev  = '0;
                end else if (reject) begin
                    n_state = ST_IDLE;
                    n_prev  = '0;
                end else if (c_x > m4) begin
                    n_state = ST_IDLE;       // too much motion, keep previous count
                end else if (n_cnt > (FB+1)'(MAX_TRACK_FRAMES)) begin
                    n_state = ST_IDLE;       // timeout
                    n_prev  = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_prev   <= '0;
            r_peak   <= '0;
            r_frames <= '0;
            r_v4     <= 1'b0;
            r_blink  <= 1'b0;
            r_cap    <= 1'b0;
        end else begin
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (fire) begin
                r_state  <= n_state;
                r_prev   <= n_prev;
                r_peak   <= n_peak;
                r_frames <= n_frames;
                r_blink  <= n_blink;
                r_cap    <= n_cap;
            end
        end
    end

    assign o_rsp.valid             = r_v4;
    assign o_rsp.blink             = r_blink;
    assign o_rsp.capture_reference = r_cap;
    assign o_rsp.tracking          = (r_state == ST_TRACK);

endmodule

@@ src/mbd_checker.sv @@
// Port-level assertion checker for the motion blink event detector, with its bind.
module mbd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_blink,
    input logic i_capture,
    input logic i_tracking
);

    // blink always ends tracking
    a_blink_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_blink |-> !i_tracking)
        else $error("blink reported while still tracking");

    // capture only on the frame that enters tracking
    a_capture_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_capture |-> i_tracking && !i_blink)
        else $error("capture without entering tracking");

    // a response held by the sink keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_blink)
            && $stable(i_capture) && $stable(i_tracking))
        else $error("stalled response changed");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind motion_blink_event_detector_top mbd_checker u_mbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_blink     (o_rsp.blink),
    .i_capture   (o_rsp.capture_reference),
    .i_tracking  (o_rsp.tracking)
);
